FILE: hw/rtl/cbpm_pkg.sv
// Shared types, codes and sizes for the clock buffer pool manager.
package cbpm_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int MAX_RESULTS = 16;
    localparam int QDEPTH = 2;

    localparam logic [2:0] CMD_READ    = 3'd0;
    localparam logic [2:0] CMD_UNPIN   = 3'd1;
    localparam logic [2:0] CMD_ALLOC   = 3'd2;
    localparam logic [2:0] CMD_DISPOSE = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LOADED  = 3'd1;
    localparam logic [2:0] ST_ALLPIN  = 3'd2;
    localparam logic [2:0] ST_NOTPIN  = 3'd3;
    localparam logic [2:0] ST_PINNED  = 3'd4;
    localparam logic [2:0] ST_BADFRM  = 3'd5;
    localparam logic [2:0] ST_ABSENT  = 3'd6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  file_id;
        logic [31:0] page_no;
        logic        mark_dirty;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        write_back;
        logic [7:0]  wb_file;
        logic [31:0] wb_page;
        logic        fetch;
        logic        last;
    } res_t;
endpackage

FILE: hw/rtl/cbpm_cmd_queue.sv
// Command queue between front end and frame engine.
module cbpm_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cbpm_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output cbpm_pkg::cmd_t out_cmd
);
    import cbpm_pkg::*;
    localparam int AW = $clog2(QDEPTH);
    cmd_t mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule

FILE: hw/rtl/cbpm_engine.sv
// Frame engine: lookup, clock sweep, flush scan and frame state.
module cbpm_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  cbpm_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output cbpm_pkg::res_t  res
);
    import cbpm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    cmd_t c_reg;
    logic [NUM_FRAMES-1:0] valid_reg, dirty_reg, ref_reg;
    logic [7:0] pins_reg [NUM_FRAMES];
    logic [7:0] file_reg [NUM_FRAMES];
    logic [31:0] page_reg [NUM_FRAMES];
    logic [FW-1:0] hand_reg, idx_reg;
    logic [FW:0] cnt_reg;
    logic [$clog2(MAX_RESULTS+1)-1:0] n_reg;
    logic hit_reg;
    logic [FW-1:0] hit_idx_reg;
    logic allpin_reg;
    res_t out_reg;
    logic out_valid_reg, out_done_reg;
    logic pend_reg;
    res_t pend_res_reg;

    // one-item lookahead for flush so the final beat carries last
    logic match_c;
    logic [FW-1:0] nh;
    assign match_c = valid_reg[idx_reg] && file_reg[idx_reg] == c_reg.file_id
                     && page_reg[idx_reg] == c_reg.page_no;
    assign nh = (hand_reg == FW'(NUM_FRAMES-1)) ? '0 : hand_reg + 1'b1;

    // a new command starts only once the previous beat has left
    assign cmd_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    function automatic res_t mk(input logic [2:0] s, input logic [FW-1:0] f,
                                input logic l);
        res_t r;
        r = '0;
        r.status = s;
        r.frame = 4'(f);
        r.last = l;
        return r;
    endfunction

    function automatic res_t mkf(input logic [2:0] s, input logic [FW-1:0] f,
                                 input logic wb, input logic [7:0] wf,
                                 input logic [31:0] wp, input logic fe,
                                 input logic l);
        res_t r;
        r.status = s;
        r.frame = 4'(f);
        r.write_back = wb;
        r.wb_file = wf;
        r.wb_page = wp;
        r.fetch = fe;
        r.last = l;
        return r;
    endfunction

    function automatic res_t fin(input res_t a);
        res_t r;
        r = a;
        r.last = 1'b1;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) pins_reg[i] <= '0;
            hand_reg <= FW'(NUM_FRAMES-1);
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end else begin
            if (out_valid_reg && res_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && !out_valid_reg) begin
                        c_reg <= cmd;
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        hit_reg <= 1'b0;
                        allpin_reg <= 1'b1;
                        n_reg <= '0;
                        pend_reg <= 1'b0;
                        state_reg <= (cmd.cmd == CMD_FLUSH) ? S_FLUSH : S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (match_c && !hit_reg) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (valid_reg[idx_reg] == 1'b0 || pins_reg[idx_reg] == 8'd0)
                        allpin_reg <= 1'b0;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == FW'(NUM_FRAMES-1)) begin
                        state_reg <= S_OUT;
                        case (c_reg.cmd)
                            CMD_READ, CMD_ALLOC: begin
                                if (!(hit_reg || match_c)) begin
                                    if (allpin_reg && valid_reg[idx_reg]
                                        && pins_reg[idx_reg] != 8'd0)
                                        out_reg <= mk(ST_ALLPIN, hand_reg, 1'b1);
                                    else
                                        state_reg <= S_SWEEP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWEEP: begin
                    hand_reg <= nh;
                    if (!valid_reg[nh]) begin
                        out_reg <= mkf(ST_LOADED, nh, 1'b0, 8'd0, 32'd0,
                                       c_reg.cmd == CMD_READ, 1'b1);
                        hit_idx_reg <= nh;
                        state_reg <= S_OUT;
                        out_done_reg <= 1'b1;
                    end else if (ref_reg[nh]) begin
                        ref_reg[nh] <= 1'b0;
                    end else if (pins_reg[nh] == 8'd0) begin
                        out_reg <= mkf(ST_LOADED, nh, dirty_reg[nh],
                                       dirty_reg[nh] ? file_reg[nh] : 8'd0,
                                       dirty_reg[nh] ? page_reg[nh] : 32'd0,
                                       c_reg.cmd == CMD_READ, 1'b1);
                        hit_idx_reg <= nh;
                        state_reg <= S_OUT;
                        out_done_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                        if (out_done_reg) begin
                            out_done_reg <= 1'b0;
                            valid_reg[hit_idx_reg] <= 1'b1;
                            dirty_reg[hit_idx_reg] <= 1'b0;
                            ref_reg[hit_idx_reg] <= 1'b1;
                            pins_reg[hit_idx_reg] <= 8'd1;
                            file_reg[hit_idx_reg] <= c_reg.file_id;
                            page_reg[hit_idx_reg] <= c_reg.page_no;
                        end else if (out_reg.status != ST_ALLPIN
                                     || !(c_reg.cmd == CMD_READ
                                          || c_reg.cmd == CMD_ALLOC)
                                     || hit_reg) begin
                            case (c_reg.cmd)
                                CMD_READ: begin
                                    ref_reg[hit_idx_reg] <= 1'b1;
                                    if (pins_reg[hit_idx_reg] != 8'd255)
                                        pins_reg[hit_idx_reg] <=
                                            pins_reg[hit_idx_reg] + 8'd1;
                                    out_reg <= mk(ST_OK, hit_idx_reg, 1'b1);
                                end
                                CMD_ALLOC: begin
                                    dirty_reg[hit_idx_reg] <= 1'b0;
                                    ref_reg[hit_idx_reg] <= 1'b1;
                                    pins_reg[hit_idx_reg] <= 8'd1;
                                    out_reg <= mk(ST_LOADED, hit_idx_reg, 1'b1);
                                end
                                CMD_UNPIN: begin
                                    if (!hit_reg)
                                        out_reg <= mk(ST_ABSENT, '0, 1'b1);
                                    else if (pins_reg[hit_idx_reg] == 8'd0)
                                        out_reg <= mk(ST_NOTPIN, hit_idx_reg, 1'b1);
                                    else begin
                                        pins_reg[hit_idx_reg] <=
                                            pins_reg[hit_idx_reg] - 8'd1;
                                        if (c_reg.mark_dirty)
                                            dirty_reg[hit_idx_reg] <= 1'b1;
                                        out_reg <= mk(ST_OK, hit_idx_reg, 1'b1);
                                    end
                                end
                                CMD_DISPOSE: begin
                                    if (!hit_reg)
                                        out_reg <= mk(ST_ABSENT, '0, 1'b1);
                                    else begin
                                        valid_reg[hit_idx_reg] <= 1'b0;
                                        dirty_reg[hit_idx_reg] <= 1'b0;
                                        ref_reg[hit_idx_reg] <= 1'b0;
                                        pins_reg[hit_idx_reg] <= 8'd0;
                                        out_reg <= mk(ST_OK, hit_idx_reg, 1'b1);
                                    end
                                end
                                default: out_reg <= mk(ST_BADFRM, '0, 1'b1);
                            endcase
                        end
                    end
                end
                S_FLUSH: begin
                    // pend holds the previous result beat until its last flag is known
                    if (!(pend_reg && out_valid_reg)) begin
                        if (cnt_reg == (FW+1)'(NUM_FRAMES)) begin
                            if (pend_reg) begin
                                out_reg <= fin(pend_res_reg);
                            end else begin
                                out_reg <= mk(ST_OK, '0, 1'b1);
                            end
                            out_valid_reg <= 1'b1;
                            pend_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end else if (valid_reg[idx_reg]
                                     && file_reg[idx_reg] == c_reg.file_id) begin
                            if (pins_reg[idx_reg] != 8'd0
                                || dirty_reg[idx_reg]) begin
                                if (n_reg == ($bits(n_reg))'(MAX_RESULTS)) begin
                                    out_reg <= fin(pend_res_reg);
                                    out_valid_reg <= 1'b1;
                                    pend_reg <= 1'b0;
                                    state_reg <= S_IDLE;
                                end else if (pins_reg[idx_reg] != 8'd0) begin
                                    if (pend_reg) begin
                                        out_reg <= pend_res_reg;
                                        out_valid_reg <= 1'b1;
                                    end
                                    pend_res_reg <= mk(ST_PINNED, idx_reg, 1'b1);
                                    pend_reg <= 1'b1;
                                    cnt_reg <= (FW+1)'(NUM_FRAMES);
                                    n_reg <= n_reg + 1'b1;
                                end else begin
                                    if (pend_reg) begin
                                        out_reg <= pend_res_reg;
                                        out_valid_reg <= 1'b1;
                                    end
                                    pend_res_reg <= mkf(ST_OK, idx_reg, 1'b1,
                                                        file_reg[idx_reg],
                                                        page_reg[idx_reg],
                                                        1'b0, 1'b0);
                                    pend_reg <= 1'b1;
                                    n_reg <= n_reg + 1'b1;
                                    valid_reg[idx_reg] <= 1'b0;
                                    dirty_reg[idx_reg] <= 1'b0;
                                    ref_reg[idx_reg] <= 1'b0;
                                    idx_reg <= idx_reg + 1'b1;
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end else begin
                                valid_reg[idx_reg] <= 1'b0;
                                ref_reg[idx_reg] <= 1'b0;
                                idx_reg <= idx_reg + 1'b1;
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/clock_buffer_pool_manager.sv
// Top level of the clock buffer pool manager.
//  channel | dir | tdata fields (low first)                        | tuser
//  s_      | in  | cmd, file_id, page_no, mark_dirty               | -
//  m_      | out | status, frame, write_back, wb_file, wb_page, fetch | tlast = last
// Lookup visits every frame in turn; a miss on read or alloc then runs the clock sweep,
// and a flush scans the frames and sends its result beats.
// A two-entry command queue lets the front take beats while the engine works.
// Reset (aresetn low, synchronous) clears valid, dirty, ref and pins of every frame; hand goes to the last frame.
// m_tready low holds the engine at its output register.
module clock_buffer_pool_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd[2:0], file_id[10:3], page_no[42:11], mark_dirty[43]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], frame[6:3], write_back[7], wb_file[15:8],
                                   // wb_page[47:16], fetch[48]
    output logic        m_tlast
);
    import cbpm_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t r;

    assign in_cmd.cmd = s_tdata[2:0];
    assign in_cmd.file_id = s_tdata[10:3];
    assign in_cmd.page_no = s_tdata[42:11];
    assign in_cmd.mark_dirty = s_tdata[43];

    cbpm_cmd_queue u_q (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    cbpm_engine u_eng (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
    );

    assign m_tdata = {7'd0, r.fetch, r.wb_page, r.wb_file, r.write_back, r.frame, r.status};
    assign m_tlast = r.last;

    a_wb_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_LOADED)
        else $error("write-back on wrong status");
    a_fetch_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> m_tdata[2:0] == ST_LOADED && m_tlast)
        else $error("fetch on wrong status");
endmodule
